@@ sv/slpz_pkg.sv @@
// ----------------------------------------------------------------------------
// slpz_pkg
// Shared types and constants for the sliding puzzle heuristic engine.
// ----------------------------------------------------------------------------
package slpz_pkg;

  // board geometry
  localparam int         MAX_SIDE    = 16;
  localparam logic [4:0] SIDE_MIN    = 5'd2;
  localparam logic [4:0] SIDE_RESET  = 5'd4;
  localparam int         STORE_DEPTH = 256;
  localparam int         TILE_W      = 8;

  // result saturation
  localparam logic [13:0] HEUR_MAX = 14'h3FFF;

  // item opcodes
  localparam logic OP_GOAL = 1'b0;
  localparam logic OP_CELL = 1'b1;

  // per-cell goal info built in the Manhattan pass, used by the pair pass
  typedef struct packed {
    logic       in_row;  // tile sits in its goal row
    logic       in_col;  // tile sits in its goal column
    logic [6:0] grow;    // goal row
    logic [3:0] gcol;    // goal column
  } meta_t;

endpackage

@@ sv/sliding_puzzle_linear_conflict.sv @@
// ----------------------------------------------------------------------------
// sliding_puzzle_linear_conflict
// Manhattan distance plus linear conflict heuristic for a square tile board.
// ----------------------------------------------------------------------------
// Goal table loads (opcode 0) and board cells (opcode 1) are taken one per
// cycle with busy low. A cell with last set starts the computation and busy
// stays high until the result is out. The Manhattan pass visits each of the
// side*side cells in turn: a blank is only read, while a tile also waits on
// the shared bit-serial divider that splits the goal index into row and column.
// The pair pass then checks side*side*(side-1) pairs, reading each pair through
// the two read ports of the per-cell goal memory. The result appears on
// out_heuristic for exactly one cycle with out_valid high and cannot be held
// off, so the receiver must take it then. Board cells beyond the fill count
// read as blank, so no clearing pass is needed between boards.
module sliding_puzzle_linear_conflict import slpz_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic              in_opcode,
  input  logic [TILE_W-1:0] in_tile,
  input  logic [TILE_W-1:0] in_goal_cell,
  input  logic              in_last,
  input  logic              cfg_we,
  input  logic [4:0]        cfg_wdata,
  output logic              out_valid,
  output logic [13:0]       out_heuristic
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_BRD  = 4'd1;
  localparam logic [3:0] ST_GRD  = 4'd2;
  localparam logic [3:0] ST_DIVS = 4'd3;
  localparam logic [3:0] ST_DIVW = 4'd4;
  localparam logic [3:0] ST_PRD  = 4'd5;
  localparam logic [3:0] ST_PCMP = 4'd6;
  localparam logic [3:0] ST_DONE = 4'd7;

  logic [3:0]  state_r;
  logic [4:0]  side_r;
  logic [4:0]  s_r;
  logic [8:0]  cells_r;
  logic [8:0]  cnt_r;
  logic [7:0]  i_r;
  logic [3:0]  row_r;
  logic [3:0]  col_r;
  logic [15:0] man_r;
  logic [11:0] conf_r;
  logic        pass_r;
  logic [3:0]  line_r;
  logic [3:0]  a_r;
  logic [3:0]  b_r;
  logic        out_valid_r;
  logic [13:0] out_heur_r;

  // memories
  logic [TILE_W-1:0] goal_mem  [STORE_DEPTH];
  logic [TILE_W-1:0] board_mem [STORE_DEPTH];
  meta_t             meta_mem  [STORE_DEPTH];
  logic [TILE_W-1:0] board_q;
  logic [TILE_W-1:0] goal_q;
  meta_t             meta_a_q;
  meta_t             meta_b_q;

  logic [4:0]  s_eff;
  logic [9:0]  cells_full;
  logic [8:0]  cells_eff;
  logic        accept;
  logic        goal_we;
  logic        board_we;
  logic [7:0]  board_wdata;
  logic        blank;
  logic        meta_we;
  meta_t       meta_wdata;
  logic        last_cell;
  logic        col_wrap;
  logic [8:0]  prod_a;
  logic [8:0]  prod_b;
  logic [7:0]  addr_a;
  logic [7:0]  addr_b;
  logic        conflict;
  logic [6:0]  drow;
  logic [3:0]  dcol;
  logic [16:0] total;

  logic        div_start;
  logic        div_done;
  logic [7:0]  div_quo;
  logic [4:0]  div_rem;

  // side in effect, clamped to the supported range
  always_comb begin
    if (side_r < SIDE_MIN) begin
      s_eff = SIDE_MIN;
    end else if (side_r > 5'(MAX_SIDE)) begin
      s_eff = 5'(MAX_SIDE);
    end else begin
      s_eff = side_r;
    end
  end
  assign cells_full = {5'd0, s_eff} * {5'd0, s_eff};
  assign cells_eff  = cells_full[8:0];

  // input transfer decode
  assign accept      = start && !busy;
  assign goal_we     = accept && (in_opcode == OP_GOAL);
  assign board_we    = accept && (in_opcode == OP_CELL) && !cnt_r[8];
  assign board_wdata = (cnt_r < cells_eff) ? in_tile : '0;

  // Manhattan pass
  assign blank     = (board_q == '0) || ({1'b0, i_r} >= cnt_r);
  assign last_cell = ({1'b0, i_r} + 9'd1) == cells_r;
  assign col_wrap  = ({1'b0, col_r} + 5'd1) == s_r;
  assign div_start = (state_r == ST_DIVS);
  assign drow = ({3'd0, row_r} > div_quo[6:0]) ? ({3'd0, row_r} - div_quo[6:0])
                                               : (div_quo[6:0] - {3'd0, row_r});
  assign dcol = (col_r > div_rem[3:0]) ? (col_r - div_rem[3:0])
                                       : (div_rem[3:0] - col_r);

  always_comb begin
    meta_wdata = '0;
    if (state_r == ST_DIVW) begin
      meta_wdata.in_row = (div_quo[6:0] == {3'd0, row_r});
      meta_wdata.in_col = (div_rem[3:0] == col_r);
      meta_wdata.grow   = div_quo[6:0];
      meta_wdata.gcol   = div_rem[3:0];
    end
  end
  assign meta_we = ((state_r == ST_GRD) && blank) || ((state_r == ST_DIVW) && div_done);

  // pair pass addressing: row pass walks line*s+x, column pass x*s+line
  assign prod_a = {5'd0, (pass_r ? a_r : line_r)} * {4'd0, s_r};
  assign prod_b = {5'd0, (pass_r ? b_r : line_r)} * {4'd0, s_r};
  assign addr_a = prod_a[7:0] + {4'd0, (pass_r ? line_r : a_r)};
  assign addr_b = prod_b[7:0] + {4'd0, (pass_r ? line_r : b_r)};

  always_comb begin
    if (!pass_r) begin
      conflict = meta_a_q.in_row && meta_b_q.in_row && (meta_a_q.gcol > meta_b_q.gcol);
    end else begin
      conflict = meta_a_q.in_col && meta_b_q.in_col && (meta_a_q.grow > meta_b_q.grow);
    end
  end

  assign total = {1'b0, man_r} + {4'd0, conf_r, 1'b0};

  // memory ports
  always_ff @(posedge clk) begin
    if (goal_we) begin
      goal_mem[in_tile] <= in_goal_cell;
    end
    goal_q <= goal_mem[board_q];
  end

  always_ff @(posedge clk) begin
    if (board_we) begin
      board_mem[cnt_r[7:0]] <= board_wdata;
    end
    board_q <= board_mem[i_r];
  end

  always_ff @(posedge clk) begin
    if (meta_we) begin
      meta_mem[i_r] <= meta_wdata;
    end
    meta_a_q <= meta_mem[addr_a];
    meta_b_q <= meta_mem[addr_b];
  end

  // shared divider
  slpz_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (goal_q),
    .divisor  (s_r),
    .done     (div_done),
    .quo      (div_quo),
    .rem      (div_rem)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      side_r      <= SIDE_RESET;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      if (cfg_we) begin
        side_r <= cfg_wdata;
      end
      case (state_r)
        ST_IDLE: begin
          if (accept && (in_opcode == OP_CELL)) begin
            if (!cnt_r[8]) begin
              cnt_r <= cnt_r + 9'd1;
            end
            if (in_last) begin
              state_r <= ST_BRD;
              s_r     <= s_eff;
              cells_r <= cells_eff;
              i_r     <= '0;
              row_r   <= '0;
              col_r   <= '0;
              man_r   <= '0;
              conf_r  <= '0;
              pass_r  <= 1'b0;
              line_r  <= '0;
              a_r     <= 4'd0;
              b_r     <= 4'd1;
            end
          end
        end
        ST_BRD: begin
          state_r <= ST_GRD;
        end
        ST_GRD, ST_DIVW: begin
          if (state_r == ST_GRD && !blank) begin
            state_r <= ST_DIVS;
          end else if (state_r == ST_GRD || div_done) begin
            if (state_r == ST_DIVW) begin
              man_r <= man_r + {9'd0, drow} + {12'd0, dcol};
            end
            i_r <= i_r + 8'd1;
            if (col_wrap) begin
              col_r <= '0;
              row_r <= row_r + 4'd1;
            end else begin
              col_r <= col_r + 4'd1;
            end
            state_r <= last_cell ? ST_PRD : ST_BRD;
          end
        end
        ST_DIVS: begin
          state_r <= ST_DIVW;
        end
        ST_PRD: begin
          state_r <= ST_PCMP;
        end
        ST_PCMP: begin
          if (conflict) begin
            conf_r <= conf_r + 12'd1;
          end
          state_r <= ST_PRD;
          if (({1'b0, b_r} + 5'd1) < s_r) begin
            b_r <= b_r + 4'd1;
          end else if (({1'b0, a_r} + 5'd2) < s_r) begin
            a_r <= a_r + 4'd1;
            b_r <= a_r + 4'd2;
          end else if (({1'b0, line_r} + 5'd1) < s_r) begin
            line_r <= line_r + 4'd1;
            a_r    <= 4'd0;
            b_r    <= 4'd1;
          end else if (!pass_r) begin
            pass_r <= 1'b1;
            line_r <= '0;
            a_r    <= 4'd0;
            b_r    <= 4'd1;
          end else begin
            state_r <= ST_DONE;
          end
        end
        ST_DONE: begin
          out_valid_r <= 1'b1;
          out_heur_r  <= (total > {3'd0, HEUR_MAX}) ? HEUR_MAX : total[13:0];
          cnt_r       <= '0;
          state_r     <= ST_IDLE;
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy          = (state_r != ST_IDLE);
  assign out_valid     = out_valid_r;
  assign out_heuristic = out_heur_r;

  // checks
  a_done_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE) |=> (out_valid_r && !busy))
    else $error("result strobe missing after done");

  a_div_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_DIVW))
    else $error("divider finished outside wait state");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 9'(STORE_DEPTH))
    else $error("cell counter beyond store depth");

  a_no_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !(board_we || goal_we))
    else $error("store written during computation");

endmodule

@@ sv/slpz_div.sv @@
// ----------------------------------------------------------------------------
// slpz_div
// Restoring divider, one quotient bit per cycle: goal index / side.
// ----------------------------------------------------------------------------
module slpz_div import slpz_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [TILE_W-1:0] dividend,
  input  logic [4:0]        divisor,
  output logic              done,
  output logic [TILE_W-1:0] quo,
  output logic [4:0]        rem
);

  logic              run_r;
  logic              done_r;
  logic [2:0]        step_r;
  logic [TILE_W-1:0] dvd_r;
  logic [TILE_W-1:0] quo_r;
  logic [4:0]        rem_r;

  logic [5:0] trial;
  logic [5:0] diff;
  logic       fits;

  // trial subtract of the next partial remainder
  assign trial = {rem_r, dvd_r[TILE_W-1]};
  assign fits  = trial >= {1'b0, divisor};
  assign diff  = trial - {1'b0, divisor};

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      step_r <= 3'd0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r  <= 1'b1;
        step_r <= 3'd0;
      end else if (run_r) begin
        step_r <= step_r + 3'd1;
        if (step_r == 3'd7) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      quo_r <= '0;
      rem_r <= '0;
    end else if (run_r) begin
      dvd_r <= {dvd_r[TILE_W-2:0], 1'b0};
      quo_r <= {quo_r[TILE_W-2:0], fits};
      rem_r <= fits ? diff[4:0] : trial[4:0];
    end
  end

  assign done = done_r;
  assign quo  = quo_r;
  assign rem  = rem_r;

endmodule
